// File: hw/rtl/mnd_pkg.sv
// Shared types, codes and format tables for the MessagePack number decoder.
package mnd_pkg;

    // Expected formats, as carried on the kind field
    localparam logic [3:0] FMT_PFIX = 4'd0;
    localparam logic [3:0] FMT_NFIX = 4'd1;
    localparam logic [3:0] FMT_U8   = 4'd2;
    localparam logic [3:0] FMT_U16  = 4'd3;
    localparam logic [3:0] FMT_U32  = 4'd4;
    localparam logic [3:0] FMT_U64  = 4'd5;
    localparam logic [3:0] FMT_I8   = 4'd6;
    localparam logic [3:0] FMT_I16  = 4'd7;
    localparam logic [3:0] FMT_I32  = 4'd8;
    localparam logic [3:0] FMT_I64  = 4'd9;
    localparam logic [3:0] FMT_F32  = 4'd10;
    localparam logic [3:0] FMT_F64  = 4'd11;

    // Fixint masks
    localparam logic [7:0] PFIX_MASK  = 8'h80;
    localparam logic [7:0] PFIX_VALUE = 8'h7f;
    localparam logic [7:0] NFIX_MASK  = 8'he0;

    // Operations handed from front to back
    localparam logic [1:0] OP_ERR  = 2'd0;
    localparam logic [1:0] OP_FIXP = 2'd1;
    localparam logic [1:0] OP_FIXN = 2'd2;
    localparam logic [1:0] OP_BYTE = 2'd3;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [1:0] op;
        logic       first;
        logic       last;
        logic [3:0] fmt;
        logic [7:0] data;
    } t_op;

    function automatic logic [7:0] type_code(input logic [3:0] fmt);
        logic [7:0] code;
        unique case (fmt)
            FMT_U8:  code = 8'hcc;
            FMT_U16: code = 8'hcd;
            FMT_U32: code = 8'hce;
            FMT_U64: code = 8'hcf;
            FMT_I8:  code = 8'hd0;
            FMT_I16: code = 8'hd1;
            FMT_I32: code = 8'hd2;
            FMT_I64: code = 8'hd3;
            FMT_F32: code = 8'hca;
            FMT_F64: code = 8'hcb;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

    function automatic logic [3:0] payload_len(input logic [3:0] fmt);
        logic [3:0] len;
        unique case (fmt)
            FMT_U8, FMT_I8:            len = 4'd1;
            FMT_U16, FMT_I16:          len = 4'd2;
            FMT_U32, FMT_I32, FMT_F32: len = 4'd4;
            FMT_U64, FMT_I64, FMT_F64: len = 4'd8;
            default:                   len = 4'd0;
        endcase
        return len;
    endfunction

endpackage

// File: hw/rtl/mnd_if.sv
// Valid/ready channel interfaces for the decoder's input bytes and results.
interface mnd_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface mnd_out_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [63:0] value;

    modport source (output valid, output status, output value, input ready);
    modport sink   (input valid, input status, input value, output ready);
endinterface

// File: hw/rtl/msgpack_number_decoder.sv
// MessagePack numeric decoder top level: front end, operation queue and back end.
// Throughput: one stream byte per cycle while the queue is not full, set by the combinational front end check.
// A byte that completes a result is written into the queue, and the back end registers the result beat when it pops it.
// A four-entry queue lets the front keep taking bytes while a result waits on o_out.
// Reset (synchronous, active low) empties the queue, drops any pending result and
// returns the front end to waiting for a type byte.
module msgpack_number_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mnd_in_if.sink     i_in,
    mnd_out_if.source  o_out
);
    import mnd_pkg::*;

    logic push, pop, full, q_valid;
    t_op  push_op, pop_op;

    mnd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_op    (push_op)
    );

    mnd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_op    (pop_op)
    );

    mnd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_op    (pop_op),
        .o_pop   (pop),
        .o_out   (o_out)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full)
        else $error("queue pushed while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid)
        else $error("queue popped while empty");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status) |-> (o_out.value == 64'd0))
        else $error("type error beat carries a nonzero value");

    a_push_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (i_in.valid && i_in.ready))
        else $error("queue push without an accepted input beat");

endmodule

// File: hw/rtl/mnd_front.sv
// Front end: accepts stream bytes, checks type bytes and tracks payload position.
module mnd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mnd_in_if.sink        i_in,
    input  logic          i_full,
    output logic          o_push,
    output mnd_pkg::t_op  o_op
);
    import mnd_pkg::*;

    logic [3:0] r_bytes_left, n_bytes_left;
    logic [3:0] r_fmt, n_fmt;
    logic       accept;
    logic       ok;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        priority if (i_in.kind > FMT_F64) begin
            ok = 1'b0;
        end else if (i_in.kind == FMT_PFIX) begin
            ok = (i_in.data_byte & PFIX_MASK) == 8'h00;
        end else if (i_in.kind == FMT_NFIX) begin
            ok = (i_in.data_byte & NFIX_MASK) == NFIX_MASK;
        end else begin
            ok = i_in.data_byte == type_code(i_in.kind);
        end
    end

    always_comb begin
        n_bytes_left = r_bytes_left;
        n_fmt        = r_fmt;
        o_push       = 1'b0;
        o_op.op      = OP_BYTE;
        o_op.first   = 1'b0;
        o_op.last    = 1'b0;
        o_op.fmt     = r_fmt;
        o_op.data    = i_in.data_byte;
        if (accept) begin
            if (r_bytes_left == 4'd0) begin
                // type byte
                priority if (!ok) begin
                    o_push  = 1'b1;
                    o_op.op = OP_ERR;
                end else if (i_in.kind == FMT_PFIX) begin
                    o_push  = 1'b1;
                    o_op.op = OP_FIXP;
                end else if (i_in.kind == FMT_NFIX) begin
                    o_push  = 1'b1;
                    o_op.op = OP_FIXN;
                end else begin
                    n_bytes_left = payload_len(i_in.kind);
                    n_fmt        = i_in.kind;
                end
            end else begin
                o_push       = 1'b1;
                o_op.first   = r_bytes_left == payload_len(r_fmt);
                o_op.last    = r_bytes_left == 4'd1;
                n_bytes_left = r_bytes_left - 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= 4'd0;
            r_fmt        <= FMT_PFIX;
        end else begin
            r_bytes_left <= n_bytes_left;
            r_fmt        <= n_fmt;
        end
    end

endmodule

// File: hw/rtl/mnd_queue.sv
// Short register queue between front end and back end.
module mnd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mnd_pkg::t_op  i_op,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output mnd_pkg::t_op  o_op
);
    import mnd_pkg::*;

    t_op          r_mem [QDEPTH];
    logic [QAW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QAW:0]   r_count;

    assign o_full  = r_count == (QAW+1)'(QDEPTH);
    assign o_valid = r_count != '0;
    assign o_op    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/mnd_back.sv
// Back end: assembles big-endian payloads, extends them and holds the result beat.
module mnd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  mnd_pkg::t_op  i_op,
    output logic          o_pop,
    mnd_out_if.source     o_out
);
    import mnd_pkg::*;

    logic [63:0] r_asm, n_asm;
    logic        r_out_valid, n_out_valid;
    logic        r_status, n_status;
    logic [63:0] r_value, n_value;
    logic        slot_free;

    assign slot_free    = !r_out_valid || o_out.ready;
    assign o_pop        = i_valid && slot_free;
    assign o_out.valid  = r_out_valid;
    assign o_out.status = r_status;
    assign o_out.value  = r_value;

    always_comb begin
        n_asm       = r_asm;
        n_out_valid = r_out_valid && !o_out.ready;
        n_status    = r_status;
        n_value     = r_value;
        if (o_pop) begin
            unique case (i_op.op)
                OP_ERR: begin
                    n_out_valid = 1'b1;
                    n_status    = 1'b1;
                    n_value     = '0;
                end
                OP_FIXP: begin
                    n_out_valid = 1'b1;
                    n_status    = 1'b0;
                    n_value     = {56'd0, i_op.data & PFIX_VALUE};
                end
                OP_FIXN: begin
                    n_out_valid = 1'b1;
                    n_status    = 1'b0;
                    n_value     = {{56{i_op.data[7]}}, i_op.data};
                end
                OP_BYTE: begin
                    // first byte starts a fresh word, later bytes shift in
                    n_asm = i_op.first ? {56'd0, i_op.data} : {r_asm[55:0], i_op.data};
                    if (i_op.last) begin
                        n_out_valid = 1'b1;
                        n_status    = 1'b0;
                        unique case (i_op.fmt)
                            FMT_I8:  n_value = {{56{n_asm[7]}}, n_asm[7:0]};
                            FMT_I16: n_value = {{48{n_asm[15]}}, n_asm[15:0]};
                            FMT_I32: n_value = {{32{n_asm[31]}}, n_asm[31:0]};
                            default: n_value = n_asm;
                        endcase
                    end
                end
                default: begin
                    n_asm = r_asm;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_asm    <= n_asm;
        r_status <= n_status;
        r_value  <= n_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: verif/msgpack_number_decoder_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for msgpack_number_decoder: directed cases, random byte streams and a predictor.
module msgpack_number_decoder_test;
    import mnd_pkg::*;

    localparam logic [3:0] KIND_BAD_LO = 4'd12;
    localparam logic [3:0] KIND_BAD_HI = 4'd15;
    localparam int unsigned ITEM_TARGET  = 700;
    localparam int unsigned IDLE_LIMIT   = 3000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned HOLD_AT      = 80;
    localparam int unsigned DRAIN_CYCLES = 20;

    class number_scoreboard;
        typedef struct packed {
            logic        status;
            logic [63:0] value;
        } t_number;

        t_number     expected_numbers[$];
        logic [3:0]  bytes_due;
        logic [3:0]  gather_fmt;
        logic [63:0] gathered;
        int unsigned failures;

        function new();
            bytes_due  = 4'd0;
            gather_fmt = FMT_PFIX;
            gathered   = 64'd0;
            failures   = 0;
        endfunction

        static function logic [7:0] format_code(input logic [3:0] fmt);
            case (fmt)
                FMT_U8:  return 8'hcc;
                FMT_U16: return 8'hcd;
                FMT_U32: return 8'hce;
                FMT_U64: return 8'hcf;
                FMT_I8:  return 8'hd0;
                FMT_I16: return 8'hd1;
                FMT_I32: return 8'hd2;
                FMT_I64: return 8'hd3;
                FMT_F32: return 8'hca;
                FMT_F64: return 8'hcb;
                default: return 8'h00;
            endcase
        endfunction

        static function int payload_bytes(input logic [3:0] fmt);
            case (fmt)
                FMT_U8, FMT_I8:            return 1;
                FMT_U16, FMT_I16:          return 2;
                FMT_U32, FMT_I32, FMT_F32: return 4;
                FMT_U64, FMT_I64, FMT_F64: return 8;
                default:                   return 0;
            endcase
        endfunction

        // Advance the decode state by one accepted input beat.
        function void decode_byte(input logic [3:0] kind, input logic [7:0] data_byte);
            logic        match_ok;
            logic [63:0] v;
            if (bytes_due == 4'd0) begin
                case (kind)
                    FMT_PFIX: match_ok = (data_byte & PFIX_MASK) == 8'h00;
                    FMT_NFIX: match_ok = (data_byte & NFIX_MASK) == NFIX_MASK;
                    default:  match_ok = (kind <= FMT_F64) && (data_byte == format_code(kind));
                endcase
                if (!match_ok) begin
                    expected_numbers.push_back({1'b1, 64'd0});
                end else if (kind == FMT_PFIX) begin
                    expected_numbers.push_back({1'b0, 56'd0, data_byte & PFIX_VALUE});
                end else if (kind == FMT_NFIX) begin
                    expected_numbers.push_back({1'b0, {56{data_byte[7]}}, data_byte});
                end else begin
                    gather_fmt = kind;
                    bytes_due  = 4'(payload_bytes(kind));
                    gathered   = 64'd0;
                end
            end else begin
                gathered  = {gathered[55:0], data_byte};
                bytes_due = bytes_due - 4'd1;
                if (bytes_due == 4'd0) begin
                    case (gather_fmt)
                        FMT_I8:  v = {{56{gathered[7]}}, gathered[7:0]};
                        FMT_I16: v = {{48{gathered[15]}}, gathered[15:0]};
                        FMT_I32: v = {{32{gathered[31]}}, gathered[31:0]};
                        default: v = gathered;
                    endcase
                    expected_numbers.push_back({1'b0, v});
                end
            end
        endfunction

        function void check_result(input logic status, input logic [63:0] value);
            t_number want;
            if (expected_numbers.size() == 0) begin
                $error("unexpected result beat: status %0d value %h", status, value);
                failures++;
                return;
            end
            want = expected_numbers.pop_front();
            if (status !== want.status) begin
                $error("status mismatch: expected %0d, actual %0d", want.status, status);
                failures++;
            end
            if (value !== want.value) begin
                $error("value mismatch: expected %h, actual %h", want.value, value);
                failures++;
            end
        endfunction

        function int outstanding();
            return expected_numbers.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    mnd_in_if  in_ch ();
    mnd_out_if out_ch ();

    msgpack_number_decoder i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    number_scoreboard sb;
    int unsigned      bytes_sent = 0;
    int unsigned      idle_cycles = 0;

    task automatic send_byte(input logic [3:0] kind, input logic [7:0] data_byte);
        int unsigned gap;
        // Run back to back on one stretch in four.
        gap = (((bytes_sent / 64) % 4) == 3) ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.kind      <= kind;
        in_ch.data_byte <= data_byte;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.decode_byte(kind, data_byte);
        bytes_sent++;
    endtask

    // Send a type byte for fmt, then its payload big-endian with junk on kind.
    task automatic send_value(input logic [3:0] fmt, input logic [63:0] payload);
        logic [7:0] type_byte;
        int         n;
        case (fmt)
            FMT_PFIX: type_byte = {1'b0, payload[6:0]};
            FMT_NFIX: type_byte = {3'b111, payload[4:0]};
            default:  type_byte = number_scoreboard::format_code(fmt);
        endcase
        send_byte(fmt, type_byte);
        n = number_scoreboard::payload_bytes(fmt);
        for (int i = n - 1; i >= 0; i--) begin
            send_byte(4'($urandom_range(0, 15)), 8'(payload >> (8 * i)));
        end
    endtask

    // Result side: random stalls, one long hold-off to back up the input.
    initial begin
        int unsigned results;
        int unsigned stall;
        results = 0;
        out_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (results == HOLD_AT) begin
                stall = HOLD_CYCLES;
            end else if (((results / 16) % 4) == 3) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 10);
            end
            if (stall != 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
            sb.check_result(out_ch.status, out_ch.value);
            results++;
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [63:0] payload;
        int unsigned pick;
        sb = new();
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.kind      <= FMT_PFIX;
        in_ch.data_byte <= 8'h00;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fixint edges and type errors
        send_value(FMT_PFIX, 64'h00);
        send_value(FMT_PFIX, 64'h7f);
        send_byte(FMT_PFIX, 8'h80);
        send_value(FMT_NFIX, 64'h00);
        send_value(FMT_NFIX, 64'h1f);
        send_byte(FMT_NFIX, 8'hdf);
        send_byte(FMT_U8, 8'hcd);
        send_byte(KIND_BAD_LO, 8'hcc);
        send_byte(KIND_BAD_HI, 8'h00);
        // Each payload format once, the integer ones at an edge
        send_value(FMT_U8,  64'hff);
        send_value(FMT_U16, 64'h8000);
        send_value(FMT_U32, 64'hffff_ffff);
        send_value(FMT_U64, 64'hffff_ffff_ffff_ffff);
        send_value(FMT_I8,  64'h80);
        send_value(FMT_I16, 64'h7fff);
        send_value(FMT_I32, 64'h8000_0000);
        send_value(FMT_I64, 64'h8000_0000_0000_0000);
        send_value(FMT_F32, 64'h3f80_0000);
        send_value(FMT_F64, 64'h3ff0_0000_0000_0000);

        while (bytes_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 99) < 85) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    payload = 64'd0;
                end else if (pick == 1) begin
                    payload = '1;
                end else begin
                    payload = {$urandom, $urandom};
                end
                send_value(4'($urandom_range(0, 11)), payload);
            end else begin
                send_byte(4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
            end
        end
        in_ch.valid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.failures == 0 && sb.outstanding() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// File: msgpack_number_decoder.f
hw/rtl/mnd_pkg.sv
hw/rtl/mnd_if.sv
hw/rtl/mnd_front.sv
hw/rtl/mnd_queue.sv
hw/rtl/mnd_back.sv
hw/rtl/msgpack_number_decoder.sv
verif/msgpack_number_decoder_test.sv
